// ===== hdl/bhd_pkg.sv =====
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared types and constants for the button hold detector and LED pattern
// generator.
// ----------------------------------------------------------------------------
package bhd_pkg;

  // configuration register indexes
  localparam logic CFG_LED_MODE  = 1'b0;
  localparam logic CFG_HOLD_TIME = 1'b1;

  localparam int CFG_DATA_W = 16;

  // led modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_BLINK   = 3'd2;
  localparam logic [2:0] MODE_STROBE  = 3'd3;
  localparam logic [2:0] MODE_BREATHE = 3'd4;

  localparam logic [2:0]  MODE_RESET      = MODE_OFF;
  localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;

  // event codes
  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_PRESS   = 2'd1;
  localparam logic [1:0] EVT_RELEASE = 2'd2;
  localparam logic [1:0] EVT_HOLD    = 2'd3;

  // pattern time base
  localparam logic [9:0] BLINK_LAST   = 10'd999;
  localparam logic [9:0] BLINK_HALF   = 10'd500;
  localparam logic [7:0] STROBE_LAST  = 8'd199;
  localparam logic [7:0] STROBE_HALF  = 8'd100;
  localparam logic [9:0] BREATHE_SPAN = 10'd512;
  localparam logic [7:0] DUTY_FULL    = 8'd255;

  // one tick word entering the datapath
  typedef struct packed {
    logic accept;
    logic level;
  } step_t;

endpackage

// ===== hdl/bhd_event.sv =====
// ----------------------------------------------------------------------------
// bhd_event
// Press, release and hold event detection with a saturating press timer.
// ----------------------------------------------------------------------------
module bhd_event #(
  parameter int ELAPSED_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bhd_pkg::step_t step,
  input  logic [15:0]    hold_time_ms,
  output logic [1:0]     event_code
);
  import bhd_pkg::*;

  localparam int CMP_W = (ELAPSED_WIDTH > 16) ? ELAPSED_WIDTH : 16;
  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  logic                     pressed_r, pressed_nxt;
  logic                     held_r, held_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_inc;
  logic                     over_hold;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r
                                                  : elapsed_r + 1'b1;
  assign over_hold = CMP_W'(elapsed_inc) > CMP_W'(hold_time_ms);

  always_comb begin
    pressed_nxt = pressed_r;
    held_nxt    = held_r;
    elapsed_nxt = elapsed_r;
    event_code  = EVT_NONE;
    if (step.level) begin
      if (pressed_r) begin
        elapsed_nxt = elapsed_inc;
        if (!held_r && over_hold) begin
          held_nxt   = 1'b1;
          event_code = EVT_HOLD;
        end
      end else begin
        pressed_nxt = 1'b1;
        held_nxt    = 1'b0;
        elapsed_nxt = '0;
        event_code  = EVT_PRESS;
      end
    end else if (pressed_r) begin
      pressed_nxt = 1'b0;
      held_nxt    = 1'b0;
      elapsed_nxt = '0;
      event_code  = EVT_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      held_r    <= 1'b0;
      elapsed_r <= '0;
    end else if (step.accept) begin
      pressed_r <= pressed_nxt;
      held_r    <= held_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// ===== hdl/bhd_led.sv =====
// ----------------------------------------------------------------------------
// bhd_led
// Free-running tick phases and the LED duty for the selected pattern.
// ----------------------------------------------------------------------------
module bhd_led (
  input  logic           clk,
  input  logic           rst_n,
  input  bhd_pkg::step_t step,
  input  logic [2:0]     led_mode,
  output logic [7:0]     led_level
);
  import bhd_pkg::*;

  logic [9:0] ph_1000_r, ph_1000_nxt;
  logic [7:0] ph_200_r, ph_200_nxt;
  logic [8:0] ph_br_r, ph_br_nxt;
  logic [9:0] br_down;

  assign ph_1000_nxt = (ph_1000_r >= BLINK_LAST) ? '0 : ph_1000_r + 1'b1;
  assign ph_200_nxt  = (ph_200_r >= STROBE_LAST) ? '0 : ph_200_r + 1'b1;
  assign ph_br_nxt   = ph_br_r + 1'b1;

  // falling half of the triangle; the peak of 256 clips to full duty
  assign br_down = BREATHE_SPAN - {1'b0, ph_br_r};

  always_comb begin
    case (led_mode)
      MODE_ON:      led_level = DUTY_FULL;
      MODE_BLINK:   led_level = (ph_1000_r < BLINK_HALF) ? DUTY_FULL : 8'd0;
      MODE_STROBE:  led_level = (ph_200_r < STROBE_HALF) ? DUTY_FULL : 8'd0;
      MODE_BREATHE: begin
        if (!ph_br_r[8])
          led_level = ph_br_r[7:0];
        else if (br_down[9:8] != 2'b00)
          led_level = DUTY_FULL;
        else
          led_level = br_down[7:0];
      end
      default:      led_level = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_1000_r <= '0;
      ph_200_r  <= '0;
      ph_br_r   <= '0;
    end else if (step.accept) begin
      ph_1000_r <= ph_1000_nxt;
      ph_200_r  <= ph_200_nxt;
      ph_br_r   <= ph_br_nxt;
    end
  end

endmodule

// ===== hdl/button_hold_detect_led_pattern.sv =====
// Button hold detector with LED pattern generator. Each input word is one
// millisecond tick carrying the sampled button level; each tick yields
// exactly one output word with the LED duty and an event code (none, press,
// release, hold). A word is accepted in every clock cycle and its result
// appears in the output register in the next cycle; the only throttle is that
// output register, so in_stall rises only while a result waits and out_stall
// is high. Configuration writes take effect on the next accepted tick.
// ----------------------------------------------------------------------------
// button_hold_detect_led_pattern
// Top level: configuration registers, event and LED datapaths, output
// register.
// ----------------------------------------------------------------------------
module button_hold_detect_led_pattern #(
  parameter int ELAPSED_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_button_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_led_level,
  output logic [1:0]  out_event_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [bhd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bhd_pkg::*;

  logic [2:0]  led_mode_r;
  logic [15:0] hold_time_r;
  step_t       step;
  logic [7:0]  led_level;
  logic [1:0]  event_code;
  logic        out_valid_r;
  logic [7:0]  led_level_r;
  logic [1:0]  event_code_r;

  assign in_stall    = out_valid_r && out_stall;
  assign step.accept = in_valid && !in_stall;
  assign step.level  = in_button_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_mode_r  <= MODE_RESET;
      hold_time_r <= HOLD_TIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LED_MODE:  led_mode_r  <= cfg_wdata[2:0];
        CFG_HOLD_TIME: hold_time_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  bhd_event #(
    .ELAPSED_WIDTH(ELAPSED_WIDTH)
  ) u_event (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .hold_time_ms (hold_time_r),
    .event_code   (event_code)
  );

  bhd_led u_led (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .led_mode  (led_mode_r),
    .led_level (led_level)
  );

  // load on accept, otherwise drop once the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.accept) begin
      led_level_r  <= led_level;
      event_code_r <= event_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_level  = led_level_r;
  assign out_event_code = event_code_r;

endmodule

// ===== hdl/bhd_checker.sv =====
// ----------------------------------------------------------------------------
// bhd_checker
// Port-level checks of the output register and its flow control.
// ----------------------------------------------------------------------------
module bhd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_led_level,
  input logic [1:0] out_event_code
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_led_level)
                               && $stable(out_event_code))
    else $error("stalled output word changed");

  // every accepted tick produces a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick gave no result");

  // input backpressure only while a result is stuck
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // no invented words
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
    else $error("output word repeated or invented");

endmodule

bind button_hold_detect_led_pattern bhd_checker u_bhd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_led_level  (out_led_level),
  .out_event_code (out_event_code)
);

// ===== test/bhd_tick_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bhd_tick_checker
// Watches the tick, result and register ports of the button hold detector.
// Keeps its own copy of the phase counters, press tracking and registers,
// predicts the LED duty and event code of every accepted tick word, and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module bhd_tick_checker
  import bhd_pkg::*;
#(
  parameter int ELAPSED_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_button_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_led_level,
  input  logic [1:0]            out_event_code,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending,
  output int                    ticks_checked,
  output int                    hold_events
);

  typedef struct packed {
    logic [7:0] led;
    logic [1:0] evt;
  } tick_result_t;

  tick_result_t due_results[$];

  logic [2:0]               led_mode;
  logic [15:0]              hold_ms;
  logic [9:0]               phase_k;
  logic [7:0]               phase_c;
  logic [8:0]               phase_b;
  logic                     pressed;
  logic                     held;
  logic [ELAPSED_WIDTH-1:0] elapsed;

  initial begin
    mismatches    = 0;
    pending       = 0;
    ticks_checked = 0;
    hold_events   = 0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
  endtask

  // Duty comes from the phases before this tick advances them.
  task automatic predict_tick(input logic level, output tick_result_t r);
    logic [9:0] fall;
    fall  = BREATHE_SPAN - {1'b0, phase_b};
    r.evt = EVT_NONE;
    case (led_mode)
      MODE_ON:      r.led = DUTY_FULL;
      MODE_BLINK:   r.led = (phase_k < BLINK_HALF) ? DUTY_FULL : 8'd0;
      MODE_STROBE:  r.led = (phase_c < STROBE_HALF) ? DUTY_FULL : 8'd0;
      MODE_BREATHE: begin
        if (!phase_b[8]) r.led = phase_b[7:0];
        else if (fall[8]) r.led = DUTY_FULL;  // clip the 256 peak
        else r.led = fall[7:0];
      end
      default:      r.led = 8'd0;
    endcase

    if (level) begin
      if (pressed) begin
        if (elapsed != '1) elapsed++;
        if (!held && elapsed > hold_ms) begin
          held  = 1'b1;
          r.evt = EVT_HOLD;
          hold_events++;
        end
      end else begin
        pressed = 1'b1;
        held    = 1'b0;
        elapsed = '0;
        r.evt   = EVT_PRESS;
      end
    end else if (pressed) begin
      pressed = 1'b0;
      held    = 1'b0;
      elapsed = '0;
      r.evt   = EVT_RELEASE;
    end

    phase_k = (phase_k >= BLINK_LAST) ? 10'd0 : phase_k + 10'd1;
    phase_c = (phase_c >= STROBE_LAST) ? 8'd0 : phase_c + 8'd1;
    phase_b = phase_b + 9'd1;
  endtask

  always @(posedge clk) begin
    tick_result_t r;
    tick_result_t want;
    if (!rst_n) begin
      led_mode = MODE_RESET;
      hold_ms  = HOLD_TIME_RESET;
      phase_k  = '0;
      phase_c  = '0;
      phase_b  = '0;
      pressed  = 1'b0;
      held     = 1'b0;
      elapsed  = '0;
      due_results.delete();
    end else begin
      // a tick taken at the same edge as a write still sees the old registers
      if (in_valid && !in_stall) begin
        predict_tick(in_button_level, r);
        due_results.push_back(r);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_LED_MODE) led_mode = cfg_wdata[2:0];
        else hold_ms = cfg_wdata[15:0];
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing due: led %0d event %0d",
                                  out_led_level, out_event_code));
        end else begin
          want = due_results.pop_front();
          ticks_checked++;
          if (out_led_level !== want.led) begin
            flag_mismatch($sformatf("tick %0d led_level got %0d want %0d",
                                    ticks_checked, out_led_level, want.led));
          end
          if (out_event_code !== want.evt) begin
            flag_mismatch($sformatf("tick %0d event_code got %0d want %0d",
                                    ticks_checked, out_event_code, want.evt));
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the button hold detector with LED patterns.
// Drives tick words through reset defaults, directed press and mode cases,
// then shaped random press sequences under four sender and receiver stall
// profiles. Checking lives in bhd_tick_checker.
// ----------------------------------------------------------------------------
module testbench;
  import bhd_pkg::*;

  localparam int ELAPSED_WIDTH = 16;
  localparam int QUIET_LIMIT   = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_button_level = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_LED_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [7:0]            out_led_level;
  logic [1:0]            out_event_code;

  int          mismatches;
  int          pending;
  int          ticks_checked;
  int          hold_events;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet = 0;
  logic [15:0] hold_now = HOLD_TIME_RESET;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  button_hold_detect_led_pattern #(.ELAPSED_WIDTH(ELAPSED_WIDTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_level   (out_led_level),
    .out_event_code  (out_event_code),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  bhd_tick_checker #(.ELAPSED_WIDTH(ELAPSED_WIDTH)) tick_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_level   (out_led_level),
    .out_event_code  (out_event_code),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .ticks_checked   (ticks_checked),
    .hold_events     (hold_events)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // End the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setting();
    logic [2:0] mode;
    int         pick;
    mode = 3'($urandom_range(7));
    pick = $urandom_range(9);
    drain();
    write_reg(CFG_LED_MODE, {13'($urandom), mode});
    if (pick == 0) hold_now = 16'hFFFF;
    else if (pick == 1) hold_now = 16'd0;
    else hold_now = 16'($urandom_range(40, 1));
    write_reg(CFG_HOLD_TIME, hold_now);
  endtask

  // Mostly clean press/release runs sized around the hold time, some noise.
  task automatic random_ticks(input int count);
    int sent;
    int run;
    int max_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        max_len = (hold_now > 50) ? 60 : hold_now + 6;
        run = $urandom_range(max_len, 1);
        repeat (run) send_tick(1'b1);
        sent += run;
        run = $urandom_range(12, 1);
        repeat (run) send_tick(1'b0);
      end else begin
        run = $urandom_range(8, 1);
        repeat (run) send_tick(1'($urandom_range(1)));
      end
      sent += run;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: led off, no early hold with the default hold time
    send_tick(1'b0);
    repeat (40) send_tick(1'b1);
    send_tick(1'b0);

    // zero hold time fires on the second pressed tick
    drain();
    write_reg(CFG_HOLD_TIME, 16'd0);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    drain();
    write_reg(CFG_HOLD_TIME, 16'd1);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);

    // every mode code, unused ones included, with junk above the field
    for (int m = 0; m < 8; m++) begin
      drain();
      write_reg(CFG_LED_MODE, {(m % 2) ? 13'h1FFF : 13'h0000, 3'(m)});
      send_tick(m[0]);
    end
    send_tick(1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (2) begin
        random_setting();
        random_ticks(32);
        drain();
        random_ticks(32);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks: reset defaults, all eight mode codes, short and",
             ticks_checked);
    $display("unreachable hold times, four stall profiles, %0d holds.",
             hold_events);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
